@@ sv/t2u_pkg.sv @@
// shared types, constants and encoding functions of the text to utf-8 transcoder
// no dependencies; imported by every module of the block

package t2u_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam logic [15:0] CAP_RESET   = 16'd256;

    localparam logic [7:0] ENC_LATIN1  = 8'd0;
    localparam logic [7:0] ENC_UTF16   = 8'd1;
    localparam logic [7:0] ENC_UTF16BE = 8'd2;
    localparam logic [7:0] ENC_UTF8    = 8'd3;

    localparam logic [7:0]  BOM_FF     = 8'hFF;
    localparam logic [7:0]  BOM_FE     = 8'hFE;
    localparam logic [15:0] SUR_HI_LO  = 16'hD800;
    localparam logic [15:0] SUR_HI_HI  = 16'hDBFF;
    localparam logic [15:0] SUR_LO_LO  = 16'hDC00;
    localparam logic [15:0] SUR_LO_HI  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    localparam int unsigned GRP_BYTES  = 4;
    localparam int unsigned NUM_GRPS   = 3;
    localparam int unsigned JOB_SLOTS  = GRP_BYTES * NUM_GRPS;

    // one utf-8 sequence of up to four bytes, b[0] goes out first
    typedef struct packed {
        logic [GRP_BYTES-1:0][7:0] b;
        logic [2:0]                k;
    } t_grp;

    // work for the back end caused by one request
    typedef struct packed {
        logic [JOB_SLOTS-1:0][7:0] bytes;
        logic [JOB_SLOTS-1:0]      mask;
        logic                      fin;
        logic [15:0]               len;
    } t_job;

    function automatic t_grp enc_cp(input logic [20:0] cp);
        t_grp g;
        g = '0;
        if (cp < 21'h80) begin
            g.b[0] = cp[7:0];
            g.k    = 3'd1;
        end else if (cp < 21'h800) begin
            g.b[0] = {3'b110, cp[10:6]};
            g.b[1] = {2'b10, cp[5:0]};
            g.k    = 3'd2;
        end else if (cp < SUPP_BASE) begin
            g.b[0] = {4'b1110, cp[15:12]};
            g.b[1] = {2'b10, cp[11:6]};
            g.b[2] = {2'b10, cp[5:0]};
            g.k    = 3'd3;
        end else begin
            g.b[0] = {5'b11110, cp[20:18]};
            g.b[1] = {2'b10, cp[17:12]};
            g.b[2] = {2'b10, cp[11:6]};
            g.b[3] = {2'b10, cp[5:0]};
            g.k    = 3'd4;
        end
        return g;
    endfunction

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] k;
        if (b[7] == 1'b0) begin
            k = 3'd1;
        end else if (b[7:5] == 3'b110) begin
            k = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            k = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            k = 3'd4;
        end else begin
            k = 3'd0;
        end
        return k;
    endfunction

    // k bytes plus a terminator still fit in the buffer
    function automatic logic fits(input logic [15:0] wc, input logic [2:0] k,
                                  input logic [15:0] cap);
        return (18'(wc) + 18'(k) + 18'd1) <= 18'(cap);
    endfunction

endpackage

@@ sv/text_to_utf8_transcoder_top.sv @@
// top level of the text to utf-8 transcoder
// depends on t2u_pkg, t2u_front, t2u_queue, t2u_back

// The front end takes one input byte every cycle while its job queue has room
// and decodes it in that same cycle; the back end sends one result a cycle from
// its output register while the receiver does not stall. An input byte that
// produces n results (at most seven: up to six utf-8 bytes and the terminator)
// holds the back end until all are sent, so the sustained rate is one input per
// cycle for Latin-1 ASCII and about one output byte per cycle otherwise. QDEPTH
// jobs fit between the halves before the input stalls. Capacity is read at each
// decode and may only change while the block is idle; its port is always ready.

module text_to_utf8_transcoder_top #(
    parameter int unsigned QDEPTH = t2u_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic [7:0]  i_text_encoding,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    input  logic        i_byte_present,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_is_final,
    output logic [15:0] o_text_length,
    output logic        o_run_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import t2u_pkg::*;

    logic q_full, q_empty, q_push, q_pop;
    t_job q_in, q_head;

    t2u_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_in_byte       (i_in_byte),
        .i_text_encoding (i_text_encoding),
        .i_first_byte    (i_first_byte),
        .i_last_byte     (i_last_byte),
        .i_byte_present  (i_byte_present),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_job         (q_in)
    );

    t2u_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    t2u_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (q_head),
        .i_empty       (q_empty),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_is_final    (o_is_final),
        .o_text_length (o_text_length),
        .o_run_last    (o_run_last)
    );

endmodule

@@ sv/t2u_front.sv @@
// front end: accepts input bytes, tracks per-value decoder state, builds output jobs
// depends on t2u_pkg

module t2u_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_in_byte,
    input  logic [7:0]        i_text_encoding,
    input  logic              i_first_byte,
    input  logic              i_last_byte,
    input  logic              i_byte_present,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_q_full,
    output logic              o_q_push,
    output t2u_pkg::t_job     o_q_job
);
    import t2u_pkg::*;

    logic [15:0] r_cap;
    logic [15:0] r_wcount, n_wcount;
    logic        r_stopped, n_stopped;
    logic [7:0]  r_held, n_held;
    logic        r_phase, n_phase;
    logic        r_first_pair, n_first_pair;
    logic        r_big, n_big;
    logic [15:0] r_pend, n_pend;
    logic        r_hval, n_hval;
    logic [31:0] r_seq, n_seq;
    logic [2:0]  r_need, n_need;
    logic [2:0]  r_have, n_have;

    logic        accept;
    logic        skip, go, commit;
    logic [15:0] unit;
    logic [20:0] cp_pair;
    logic [2:0]  lk;
    t_grp        cand, g0, g1, g2;
    t_grp [NUM_GRPS-1:0] grps;
    t_job        job;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = i_q_full;
    assign accept      = i_valid && !i_q_full;

    always_comb begin
        n_wcount     = i_first_byte ? '0    : r_wcount;
        n_stopped    = i_first_byte ? 1'b0  : r_stopped;
        n_held       = i_first_byte ? '0    : r_held;
        n_phase      = i_first_byte ? 1'b0  : r_phase;
        n_first_pair = i_first_byte ? 1'b1  : r_first_pair;
        n_big        = i_first_byte ? 1'b0  : r_big;
        n_pend       = i_first_byte ? '0    : r_pend;
        n_hval       = i_first_byte ? 1'b0  : r_hval;
        n_seq        = i_first_byte ? '0    : r_seq;
        n_need       = i_first_byte ? '0    : r_need;
        n_have       = i_first_byte ? '0    : r_have;
        g0      = '0;
        g1      = '0;
        g2      = '0;
        cand    = '0;
        skip    = 1'b0;
        go      = 1'b0;
        commit  = 1'b0;
        unit    = '0;
        cp_pair = '0;
        lk      = lead_len(i_in_byte);

        if (i_byte_present && !n_stopped) begin
            case (i_text_encoding)
                ENC_LATIN1: begin
                    if (i_in_byte == 8'd0) begin
                        n_stopped = 1'b1;
                    end else begin
                        cand = enc_cp({13'd0, i_in_byte});
                        if (fits(n_wcount, cand.k, r_cap)) begin
                            g0       = cand;
                            n_wcount = n_wcount + 16'(cand.k);
                        end else begin
                            n_stopped = 1'b1;
                        end
                    end
                end
                ENC_UTF16, ENC_UTF16BE: begin
                    if (!n_phase) begin
                        n_held  = i_in_byte;
                        n_phase = 1'b1;
                    end else begin
                        n_phase = 1'b0;
                        if (n_first_pair) begin
                            n_first_pair = 1'b0;
                            if (i_text_encoding != ENC_UTF16BE) begin
                                if (n_held == BOM_FF && i_in_byte == BOM_FE) begin
                                    n_big = 1'b0;
                                    skip  = 1'b1;
                                end else if (n_held == BOM_FE && i_in_byte == BOM_FF) begin
                                    n_big = 1'b1;
                                    skip  = 1'b1;
                                end else begin
                                    n_big = 1'b0;
                                end
                            end
                        end
                        if (!skip) begin
                            unit = (i_text_encoding == ENC_UTF16BE || n_big) ?
                                   {n_held, i_in_byte} : {i_in_byte, n_held};
                            go = 1'b1;
                            if (n_hval) begin
                                n_hval = 1'b0;
                                if (unit inside {[SUR_LO_LO:SUR_LO_HI]}) begin
                                    go      = 1'b0;
                                    cp_pair = SUPP_BASE + {1'b0, n_pend[9:0], 10'd0}
                                              + {11'd0, unit[9:0]};
                                    cand    = enc_cp(cp_pair);
                                    if (fits(n_wcount, cand.k, r_cap)) begin
                                        g0       = cand;
                                        n_wcount = n_wcount + 16'(cand.k);
                                    end else begin
                                        n_stopped = 1'b1;
                                    end
                                end else begin
                                    cand = enc_cp({5'd0, n_pend});
                                    if (fits(n_wcount, cand.k, r_cap)) begin
                                        g0       = cand;
                                        n_wcount = n_wcount + 16'(cand.k);
                                    end else begin
                                        n_stopped = 1'b1;
                                        go        = 1'b0;
                                    end
                                end
                            end
                            if (go) begin
                                if (unit == 16'd0) begin
                                    n_stopped = 1'b1;
                                end else if (unit inside {[SUR_HI_LO:SUR_HI_HI]}) begin
                                    n_pend = unit;
                                    n_hval = 1'b1;
                                end else begin
                                    cand = enc_cp({5'd0, unit});
                                    if (fits(n_wcount, cand.k, r_cap)) begin
                                        g1       = cand;
                                        n_wcount = n_wcount + 16'(cand.k);
                                    end else begin
                                        n_stopped = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                ENC_UTF8: begin
                    if (n_need == 3'd0) begin
                        if (i_in_byte == 8'd0 || lk == 3'd0) begin
                            n_stopped = 1'b1;
                        end else begin
                            n_seq  = {24'd0, i_in_byte};
                            n_need = lk;
                            n_have = 3'd1;
                            commit = (n_have >= n_need);
                        end
                    end else begin
                        if (n_have < 3'd4) begin
                            n_seq[{n_have[1:0], 3'b000} +: 8] = i_in_byte;
                        end
                        n_have = n_have + 3'd1;
                        commit = (n_have >= n_need);
                    end
                    if (commit) begin
                        cand.b = n_seq;
                        cand.k = n_need;
                        if (fits(n_wcount, cand.k, r_cap)) begin
                            g0       = cand;
                            n_wcount = n_wcount + 16'(cand.k);
                        end else begin
                            n_stopped = 1'b1;
                        end
                        n_need = '0;
                        n_have = '0;
                        n_seq  = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_last_byte && !n_stopped && n_hval) begin
            n_hval = 1'b0;
            cand   = enc_cp({5'd0, n_pend});
            if (fits(n_wcount, cand.k, r_cap)) begin
                g2       = cand;
                n_wcount = n_wcount + 16'(cand.k);
            end else begin
                n_stopped = 1'b1;
            end
        end

        grps = {g2, g1, g0};
        job  = '0;
        for (int g = 0; g < NUM_GRPS; g++) begin
            for (int j = 0; j < GRP_BYTES; j++) begin
                job.bytes[g*GRP_BYTES + j] = grps[g].b[j];
                job.mask[g*GRP_BYTES + j]  = (3'(j) < grps[g].k);
            end
        end
        job.fin = i_last_byte;
        job.len = i_last_byte ? n_wcount : '0;

        if (i_last_byte) begin
            n_wcount     = '0;
            n_stopped    = 1'b0;
            n_held       = '0;
            n_phase      = 1'b0;
            n_first_pair = 1'b1;
            n_big        = 1'b0;
            n_pend       = '0;
            n_hval       = 1'b0;
            n_seq        = '0;
            n_need       = '0;
            n_have       = '0;
        end
    end

    assign o_q_job  = job;
    assign o_q_push = accept && (job.fin || (|job.mask));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcount     <= '0;
            r_stopped    <= 1'b0;
            r_held       <= '0;
            r_phase      <= 1'b0;
            r_first_pair <= 1'b1;
            r_big        <= 1'b0;
            r_pend       <= '0;
            r_hval       <= 1'b0;
            r_seq        <= '0;
            r_need       <= '0;
            r_have       <= '0;
        end else if (accept) begin
            r_wcount     <= n_wcount;
            r_stopped    <= n_stopped;
            r_held       <= n_held;
            r_phase      <= n_phase;
            r_first_pair <= n_first_pair;
            r_big        <= n_big;
            r_pend       <= n_pend;
            r_hval       <= n_hval;
            r_seq        <= n_seq;
            r_need       <= n_need;
            r_have       <= n_have;
        end
    end

endmodule

@@ sv/t2u_queue.sv @@
// job queue between front and back end, register based, one push and one pop a cycle
// depends on t2u_pkg

module t2u_queue #(
    parameter int unsigned DEPTH = t2u_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t2u_pkg::t_job i_job,
    input  logic          i_pop,
    output t2u_pkg::t_job o_head,
    output logic          o_empty,
    output logic          o_full
);
    import t2u_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

@@ sv/t2u_back.sv @@
// back end: walks each queued job and sends one output byte or terminator a cycle unless stalled
// depends on t2u_pkg; takes jobs from t2u_queue

module t2u_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t2u_pkg::t_job i_head,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [7:0]    o_out_byte,
    output logic          o_is_final,
    output logic [15:0]   o_text_length,
    output logic          o_run_last
);
    import t2u_pkg::*;

    localparam int unsigned SW = $clog2(JOB_SLOTS);

    t_job        r_job, n_job;
    logic        r_ov;
    logic [7:0]  r_ob, n_ob;
    logic        r_of, n_of;
    logic [15:0] r_ol, n_ol;
    logic        r_orl, n_orl;

    t_job        src;
    logic        act, take, have_src, produce;
    logic [SW-1:0] sel;

    assign act      = r_job.fin || (|r_job.mask);
    assign src      = act ? r_job : i_head;
    assign take     = !r_ov || !i_stall;
    assign have_src = act || !i_empty;
    assign produce  = take && have_src;
    assign o_pop    = produce && !act;

    always_comb begin
        sel = '0;
        for (int i = JOB_SLOTS - 1; i >= 0; i--) begin
            if (src.mask[i]) begin
                sel = SW'(i);
            end
        end
        n_job = src;
        n_ob  = '0;
        n_of  = 1'b0;
        n_ol  = '0;
        n_orl = 1'b0;
        if (|src.mask) begin
            n_job.mask[sel] = 1'b0;
            n_ob  = src.bytes[sel];
            n_orl = !(|n_job.mask) && !src.fin;
        end else begin
            n_job.fin = 1'b0;
            n_of      = 1'b1;
            n_ol      = src.len;
            n_orl     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job.mask <= '0;
            r_job.fin  <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (produce) begin
                r_job <= n_job;
            end
            if (take) begin
                r_ov <= have_src;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_ob  <= n_ob;
            r_of  <= n_of;
            r_ol  <= n_ol;
            r_orl <= n_orl;
        end
    end

    assign o_valid       = r_ov;
    assign o_out_byte    = r_ob;
    assign o_is_final    = r_of;
    assign o_text_length = r_ol;
    assign o_run_last    = r_orl;

endmodule

@@ bench/tb_text_to_utf8_transcoder_top.sv @@
`timescale 1ns / 100ps

// self-checking bench for text_to_utf8_transcoder_top: random and directed text values
// in Latin-1, UTF-16 and UTF-8, checked byte by byte against a predictor kept here
// depends on t2u_pkg and the transcoder rtl

module tb_text_to_utf8_transcoder_top;

    import t2u_pkg::*;

    localparam logic [7:0] ENC_FIRST_BAD = ENC_UTF8 + 8'd1;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 90;
    localparam int SETTLE_CYCLES = 24;

    typedef struct packed {
        logic [7:0] in_byte;
        logic [7:0] text_encoding;
        logic       first_byte;
        logic       last_byte;
        logic       byte_present;
        logic       drain_first;
    } t_text_req;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_final;
        logic [15:0] text_length;
        logic        run_last;
    } t_utf8_res;

    typedef struct {
        logic [15:0] written;
        logic        stopped;
        logic [7:0]  held;
        logic        phase;
        logic        first_pair;
        logic        big;
        logic [15:0] pend_high;
        logic        high_ok;
        logic [31:0] seq;
        logic [2:0]  need;
        logic [2:0]  have;
    } t_value_state;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_in_byte = 8'd0;
    logic [7:0]  i_text_encoding = 8'd0;
    logic        i_first_byte = 1'b0;
    logic        i_last_byte = 1'b0;
    logic        i_byte_present = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_is_final;
    logic [15:0] o_text_length;
    logic        o_run_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = 16'd0;

    text_to_utf8_transcoder_top dut (.*);

    t_value_state text_st;
    logic [15:0]  capacity_now = t2u_pkg::CAP_RESET;
    t_utf8_res    step_results[$];
    t_utf8_res    utf8_expected[$];
    t_text_req    pending_items[$];
    t_text_req    offered;
    t_utf8_res    want;
    logic [7:0]   value_bytes[$];
    bit           drain_next = 1'b0;

    int items_queued = 0;
    int items_accepted = 0;
    int results_seen = 0;
    int mismatches = 0;
    int cfg_writes = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;
    int cycle_count = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // transcoder prediction

    function automatic void clear_text_state();
        text_st.written    = '0;
        text_st.stopped    = 1'b0;
        text_st.held       = '0;
        text_st.phase      = 1'b0;
        text_st.first_pair = 1'b1;
        text_st.big        = 1'b0;
        text_st.pend_high  = '0;
        text_st.high_ok    = 1'b0;
        text_st.seq        = '0;
        text_st.need       = '0;
        text_st.have       = '0;
    endfunction

    function automatic void add_result(logic [7:0] b, logic fin, logic [15:0] len);
        t_utf8_res r;
        r.out_byte    = b;
        r.is_final    = fin;
        r.text_length = len;
        r.run_last    = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic bit emit_utf8(logic [3:0][7:0] s, int k);
        if (int'(text_st.written) + k + 1 > int'(capacity_now)) begin
            text_st.stopped = 1'b1;
            return 1'b0;
        end
        for (int i = 0; i < k; i++) add_result(s[i], 1'b0, 16'd0);
        text_st.written = text_st.written + 16'(k);
        return 1'b1;
    endfunction

    function automatic bit emit_codepoint(logic [20:0] cp);
        logic [3:0][7:0] s;
        int k;
        s = '0;
        if (cp < 21'h80) begin
            s[0] = cp[7:0];
            k = 1;
        end else if (cp < 21'h800) begin
            s[0] = 8'hC0 | 8'(cp >> 6);
            s[1] = 8'h80 | 8'(cp & 21'h3F);
            k = 2;
        end else if (cp < SUPP_BASE) begin
            s[0] = 8'hE0 | 8'(cp >> 12);
            s[1] = 8'h80 | 8'((cp >> 6) & 21'h3F);
            s[2] = 8'h80 | 8'(cp & 21'h3F);
            k = 3;
        end else begin
            s[0] = 8'hF0 | 8'((cp >> 18) & 21'h7);
            s[1] = 8'h80 | 8'((cp >> 12) & 21'h3F);
            s[2] = 8'h80 | 8'((cp >> 6) & 21'h3F);
            s[3] = 8'h80 | 8'(cp & 21'h3F);
            k = 4;
        end
        return emit_utf8(s, k);
    endfunction

    function automatic void take_utf16_unit(logic [15:0] u);
        if (text_st.high_ok) begin
            text_st.high_ok = 1'b0;
            if (u >= SUR_LO_LO && u <= SUR_LO_HI) begin
                void'(emit_codepoint(SUPP_BASE
                    + ((21'(text_st.pend_high) - 21'(SUR_HI_LO)) << 10)
                    + (21'(u) - 21'(SUR_LO_LO))));
                return;
            end
            if (!emit_codepoint(21'(text_st.pend_high))) return;
        end
        if (u == 16'd0) begin
            text_st.stopped = 1'b1;
            return;
        end
        if (u >= SUR_HI_LO && u <= SUR_HI_HI) begin
            text_st.pend_high = u;
            text_st.high_ok = 1'b1;
            return;
        end
        void'(emit_codepoint(21'(u)));
    endfunction

    function automatic void take_utf16_byte(logic [7:0] b, bit fixed_big);
        logic [15:0] u;
        if (!text_st.phase) begin
            text_st.held = b;
            text_st.phase = 1'b1;
            return;
        end
        text_st.phase = 1'b0;
        if (text_st.first_pair) begin
            text_st.first_pair = 1'b0;
            if (!fixed_big) begin
                if (text_st.held == BOM_FF && b == BOM_FE) begin
                    text_st.big = 1'b0;
                    return;
                end
                if (text_st.held == BOM_FE && b == BOM_FF) begin
                    text_st.big = 1'b1;
                    return;
                end
                text_st.big = 1'b0;
            end
        end
        u = (fixed_big || text_st.big) ? {text_st.held, b} : {b, text_st.held};
        take_utf16_unit(u);
    endfunction

    function automatic int utf8_lead_bytes(logic [7:0] b);
        if (b < 8'h80) return 1;
        if ((b & 8'hE0) == 8'hC0) return 2;
        if ((b & 8'hF0) == 8'hE0) return 3;
        if ((b & 8'hF8) == 8'hF0) return 4;
        return 0;
    endfunction

    function automatic void take_utf8_byte(logic [7:0] b);
        int k;
        if (text_st.need == 3'd0) begin
            if (b == 8'd0) begin
                text_st.stopped = 1'b1;
                return;
            end
            k = utf8_lead_bytes(b);
            if (k == 0) begin
                text_st.stopped = 1'b1;
                return;
            end
            text_st.seq  = {24'd0, b};
            text_st.need = 3'(k);
            text_st.have = 3'd1;
        end else begin
            if (text_st.have < 3'd4) text_st.seq = text_st.seq | (32'(b) << (8 * text_st.have));
            text_st.have = text_st.have + 3'd1;
        end
        if (text_st.have >= text_st.need) begin
            void'(emit_utf8(text_st.seq, int'(text_st.need)));
            text_st.need = '0;
            text_st.have = '0;
            text_st.seq  = '0;
        end
    endfunction

    function automatic void predict_request(t_text_req rq);
        t_utf8_res r;
        step_results.delete();
        if (rq.first_byte) clear_text_state();
        if (rq.byte_present && !text_st.stopped) begin
            case (rq.text_encoding)
                ENC_LATIN1: begin
                    if (rq.in_byte == 8'd0) text_st.stopped = 1'b1;
                    else void'(emit_codepoint(21'(rq.in_byte)));
                end
                ENC_UTF16:   take_utf16_byte(rq.in_byte, 1'b0);
                ENC_UTF16BE: take_utf16_byte(rq.in_byte, 1'b1);
                ENC_UTF8:    take_utf8_byte(rq.in_byte);
                default: ;
            endcase
        end
        if (rq.last_byte) begin
            if (!text_st.stopped && text_st.high_ok) begin
                text_st.high_ok = 1'b0;
                void'(emit_codepoint(21'(text_st.pend_high)));
            end
            add_result(8'd0, 1'b1, text_st.written);
            clear_text_state();
        end
        foreach (step_results[i]) begin
            r = step_results[i];
            r.run_last = (i == step_results.size() - 1);
            utf8_expected.push_back(r);
        end
    endfunction

    // stimulus building

    function automatic void add_item(logic [7:0] b, logic [7:0] enc, logic first,
                                     logic fin, logic present);
        t_text_req rq;
        rq.in_byte       = b;
        rq.text_encoding = enc;
        rq.first_byte    = first;
        rq.last_byte     = fin;
        rq.byte_present  = present;
        rq.drain_first   = drain_next;
        drain_next = 1'b0;
        pending_items.push_back(rq);
        items_queued++;
    endfunction

    function automatic void queue_value(logic [7:0] enc, bit mixed);
        logic [7:0] e;
        int tail;
        tail = value_bytes.size() - 1;
        if (tail < 0) begin
            add_item(8'($urandom()), enc, 1'b1, 1'b1, 1'b0);
            return;
        end
        for (int i = 0; i <= tail; i++) begin
            e = enc;
            if (mixed && $urandom_range(19, 0) == 0) e = 8'($urandom_range(3, 0));
            add_item(value_bytes[i], e, i == 0, i == tail, 1'b1);
        end
    endfunction

    function automatic void add_value(logic [7:0] enc, int n, logic [0:7][7:0] seq);
        value_bytes.delete();
        for (int i = 0; i < n; i++) value_bytes.push_back(seq[i]);
        queue_value(enc, 1'b0);
    endfunction

    function automatic void push_unit(logic [15:0] u, bit big);
        if (big) begin
            value_bytes.push_back(u[15:8]);
            value_bytes.push_back(u[7:0]);
        end else begin
            value_bytes.push_back(u[7:0]);
            value_bytes.push_back(u[15:8]);
        end
    endfunction

    function automatic void add_random_unit(bit big);
        case ($urandom_range(11, 0))
            0, 1: push_unit(16'($urandom_range(16'h7F, 1)), big);
            2: push_unit(16'($urandom_range(16'h7FF, 16'h80)), big);
            3: push_unit(16'($urandom_range(16'hD7FF, 16'h800)), big);
            4: push_unit(16'($urandom_range(16'hFFFF, 16'hE000)), big);
            5, 6, 7: begin
                push_unit(16'($urandom_range(SUR_HI_HI, SUR_HI_LO)), big);
                push_unit(16'($urandom_range(SUR_LO_HI, SUR_LO_LO)), big);
            end
            8: push_unit(16'($urandom_range(SUR_HI_HI, SUR_HI_LO)), big);
            9: push_unit(16'($urandom_range(SUR_LO_HI, SUR_LO_LO)), big);
            10: push_unit(16'd0, big);
            default: push_unit(16'($urandom()), big);
        endcase
    endfunction

    function automatic void add_random_utf8_seq();
        int conts;
        bit wild;
        conts = 0;
        wild = 1'b0;
        case ($urandom_range(11, 0))
            0, 1, 2: value_bytes.push_back(8'($urandom_range(8'h7F, 1)));
            3, 4: begin
                value_bytes.push_back(8'($urandom_range(8'hDF, 8'hC0)));
                conts = 1;
            end
            5, 6: begin
                value_bytes.push_back(8'($urandom_range(8'hEF, 8'hE0)));
                conts = 2;
            end
            7, 8: begin
                value_bytes.push_back(8'($urandom_range(8'hF7, 8'hF0)));
                conts = 3;
            end
            9: value_bytes.push_back($urandom_range(1, 0) ? 8'($urandom_range(8'hBF, 8'h80))
                                                         : 8'($urandom_range(8'hFF, 8'hF8)));
            10: value_bytes.push_back(8'd0);
            default: begin
                value_bytes.push_back(8'($urandom_range(8'hEF, 8'hE0)));
                conts = 2;
                wild = 1'b1;
            end
        endcase
        repeat (conts) begin
            value_bytes.push_back(wild ? 8'($urandom()) : 8'($urandom_range(8'hBF, 8'h80)));
        end
    endfunction

    function automatic void add_random_value();
        logic [7:0] enc;
        bit big;
        value_bytes.delete();
        case ($urandom_range(9, 0))
            0, 1: begin
                enc = ENC_LATIN1;
                repeat ($urandom_range(6, 1)) begin
                    value_bytes.push_back(($urandom_range(11, 0) == 0) ? 8'd0
                                                                      : 8'($urandom_range(255, 1)));
                end
            end
            2, 3, 4: begin
                enc = $urandom_range(1, 0) ? ENC_UTF16 : ENC_UTF16BE;
                big = (enc == ENC_UTF16BE);
                if (enc == ENC_UTF16) begin
                    case ($urandom_range(2, 0))
                        1: begin
                            value_bytes.push_back(BOM_FF);
                            value_bytes.push_back(BOM_FE);
                        end
                        2: begin
                            value_bytes.push_back(BOM_FE);
                            value_bytes.push_back(BOM_FF);
                            big = 1'b1;
                        end
                        default: ;
                    endcase
                end
                repeat ($urandom_range(4, 1)) add_random_unit(big);
                if ($urandom_range(7, 0) == 0) value_bytes.push_back(8'($urandom()));
            end
            5, 6, 7: begin
                enc = ENC_UTF8;
                repeat ($urandom_range(4, 1)) add_random_utf8_seq();
                if ($urandom_range(5, 0) == 0) void'(value_bytes.pop_back());
            end
            8: begin
                enc = 8'($urandom_range(255, int'(ENC_FIRST_BAD)));
                repeat ($urandom_range(3, 0)) value_bytes.push_back(8'($urandom()));
            end
            default: enc = 8'($urandom_range(3, 0));
        endcase
        queue_value(enc, 1'b1);
    endfunction

    task automatic random_phase(int n, bit long_hold);
        int stop_at;
        int mid;
        bit marked;
        stop_at = items_queued + n;
        mid = items_queued + n / 2;
        marked = 1'b0;
        if (long_hold) holds_asked <= holds_asked + 1;
        while (items_queued < stop_at) begin
            if (!marked && items_queued >= mid) begin
                drain_next = 1'b1;
                marked = 1'b1;
            end
            if ($urandom_range(9, 0) == 0) begin
                add_item(8'($urandom()), 8'($urandom()), 1'($urandom()), 1'($urandom()),
                         1'($urandom()));
            end else begin
                add_random_value();
            end
        end
        add_item(8'd0, ENC_LATIN1, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic settle();
        while (items_accepted != items_queued || utf8_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        capacity_now = value;
        cfg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_request(offered);
                items_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_items.size() != 0
                        && !(pending_items[0].drain_first && utf8_expected.size() != 0)
                        && $urandom_range(99, 0) >= send_idle_pct) begin
                    offered = pending_items.pop_front();
                    i_valid <= 1'b1;
                    i_in_byte <= offered.in_byte;
                    i_text_encoding <= offered.text_encoding;
                    i_first_byte <= offered.first_byte;
                    i_last_byte <= offered.last_byte;
                    i_byte_present <= offered.byte_present;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_asked) begin
            hold_left <= LONG_HOLD;
            holds_served <= holds_served + 1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (utf8_expected.size() == 0) begin
                    $error("unexpected result: out_byte %0h is_final %0b", o_out_byte, o_is_final);
                    mismatches++;
                end else begin
                    want = utf8_expected.pop_front();
                    if (o_out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h", want.out_byte, o_out_byte);
                        mismatches++;
                    end
                    if (o_is_final !== want.is_final) begin
                        $error("is_final: expected %0b, got %0b", want.is_final, o_is_final);
                        mismatches++;
                    end
                    if (o_text_length !== want.text_length) begin
                        $error("text_length: expected %0d, got %0d", want.text_length,
                               o_text_length);
                        mismatches++;
                    end
                    if (o_run_last !== want.run_last) begin
                        $error("run_last: expected %0b, got %0b", want.run_last, o_run_last);
                        mismatches++;
                    end
                end
            end
            i_stall <= (hold_left != 0) || ($urandom_range(99, 0) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        clear_text_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct <= 30;
        recv_idle_pct <= 63;
        write_capacity(t2u_pkg::CAP_RESET);

        // absent byte mid value and a mixed-code sequence
        add_item(8'h01, ENC_LATIN1, 1'b1, 1'b0, 1'b1);
        add_item(8'h7F, ENC_LATIN1, 1'b0, 1'b0, 1'b1);
        add_item(8'hAA, ENC_LATIN1, 1'b0, 1'b0, 1'b0);
        add_item(8'hC3, ENC_UTF8, 1'b0, 1'b0, 1'b1);
        add_item(8'hA9, ENC_UTF8, 1'b0, 1'b0, 1'b1);
        add_item(8'hFF, ENC_LATIN1, 1'b0, 1'b1, 1'b1);
        add_value(ENC_LATIN1, 3, 64'h8000_4200_0000_0000);
        add_item(8'h00, ENC_LATIN1, 1'b1, 1'b1, 1'b0);
        add_item(8'h55, 8'hFF, 1'b1, 1'b1, 1'b1);
        add_value(ENC_UTF16, 7, 64'hFEFF_D83D_DE00_4100);
        add_value(ENC_UTF16BE, 4, 64'hD800_DBFF_0000_0000);
        add_value(ENC_UTF8, 4, 64'hE282_ACC3_0000_0000);

        settle();
        write_capacity(16'd0);
        random_phase(20, 1'b0);
        settle();
        write_capacity(16'd5);
        random_phase(45, 1'b1);

        settle();
        send_idle_pct <= 63;
        recv_idle_pct <= 30;
        write_capacity(16'hFFFF);
        random_phase(55, 1'b0);
        settle();
        write_capacity(16'd1);
        random_phase(20, 1'b0);
        settle();
        write_capacity(16'd12);
        random_phase(45, 1'b1);

        settle();
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        write_capacity(16'($urandom_range(40, 2)));
        random_phase(50, 1'b0);
        settle();
        write_capacity(t2u_pkg::CAP_RESET);
        random_phase(50, 1'b0);
        settle();

        $display("%0d text requests over %0d capacity settings, %0d utf-8 results checked",
                 items_accepted, cfg_writes, results_seen);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
